### src/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared widths, channel order and types for the six-channel window mean.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int CHANNELS       = 6;
    localparam int FILL_W         = 7;
    localparam int WINDOW_DEFAULT = 100;

    localparam int CH_PITCH   = 0;
    localparam int CH_ROLL    = 1;
    localparam int CH_YAW     = 2;
    localparam int CH_ACCEL_X = 3;
    localparam int CH_ACCEL_Y = 4;
    localparam int CH_ACCEL_Z = 5;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef sample_t [CHANNELS-1:0] sample_vec_t;

endpackage

### src/swm_if.sv
// ----------------------------------------------------------------------------
// swm_sample_if / swm_mean_if
// Valid/ready channels carrying one six-channel sample and one mean result.
// ----------------------------------------------------------------------------
interface swm_sample_if import swm_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pitch_sample;
    logic signed [SAMPLE_W-1:0] roll_sample;
    logic signed [SAMPLE_W-1:0] yaw_sample;
    logic signed [SAMPLE_W-1:0] accel_x_sample;
    logic signed [SAMPLE_W-1:0] accel_y_sample;
    logic signed [SAMPLE_W-1:0] accel_z_sample;

    modport source
    (
        output valid, pitch_sample, roll_sample, yaw_sample,
               accel_x_sample, accel_y_sample, accel_z_sample,
        input  ready
    );

    modport sink
    (
        input  valid, pitch_sample, roll_sample, yaw_sample,
               accel_x_sample, accel_y_sample, accel_z_sample,
        output ready
    );

endinterface

interface swm_mean_if import swm_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] pitch_mean;
    logic signed [SAMPLE_W-1:0] roll_mean;
    logic signed [SAMPLE_W-1:0] yaw_mean;
    logic signed [SAMPLE_W-1:0] accel_x_mean;
    logic signed [SAMPLE_W-1:0] accel_y_mean;
    logic signed [SAMPLE_W-1:0] accel_z_mean;
    logic        [FILL_W-1:0]   fill_count;

    modport source
    (
        output valid, pitch_mean, roll_mean, yaw_mean,
               accel_x_mean, accel_y_mean, accel_z_mean, fill_count,
        input  ready
    );

    modport sink
    (
        input  valid, pitch_mean, roll_mean, yaw_mean,
               accel_x_mean, accel_y_mean, accel_z_mean, fill_count,
        output ready
    );

endinterface

### src/six_channel_window_mean.sv
// ----------------------------------------------------------------------------
// six_channel_window_mean
// Boxcar moving average over six sensor channels with bit-serial division.
//
//   channel   role    beat
//   samples   sink    one sample of six signed 16-bit channels
//   means     source  six signed 16-bit means and the fill count
//
// Each sample goes through accept with ring read/write, sum update,
// divider load, then SUM_W restoring steps, one quotient bit per cycle
// in six parallel lanes, and output load; ready is low until that load.
// A result waiting on means.ready holds the block in its load step.
// Reset clears sums, fill count and write position; the ring is not cleared.
// ----------------------------------------------------------------------------
module six_channel_window_mean import swm_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    swm_sample_if.sink   samples,
    swm_mean_if.source   means
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int BIT_W = $clog2(SUM_W);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_UPDATE,
        ST_PREP,
        ST_DIVIDE,
        ST_LOAD
    } state_t;

    state_t                     state_reg;
    logic [BIT_W-1:0]           bit_cnt_reg;
    logic                       out_valid_reg;
    sample_vec_t                mean_reg;
    logic [FILL_W-1:0]          fill_out_reg;

    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic [CNT_W-1:0]           filled_reg;
    logic                       full_reg;
    logic signed [SUM_W-1:0]    sums_reg [CHANNELS];

    sample_vec_t                ring [WINDOW];
    sample_vec_t                old_reg;
    sample_vec_t                sample_reg;
    logic [SUM_W-1:0]           quo_reg  [CHANNELS];
    logic [CNT_W-1:0]           rem_reg  [CHANNELS];
    logic [CHANNELS-1:0]        neg_reg;

    sample_vec_t                in_vec;
    sample_vec_t                res_vec;
    logic                       accept;
    logic signed [SUM_W-1:0]    sum_upd  [CHANNELS];
    logic [SUM_W-1:0]           mag      [CHANNELS];
    logic [CNT_W:0]             shifted  [CHANNELS];
    logic [CHANNELS-1:0]        ge;
    logic [CNT_W-1:0]           rem_step [CHANNELS];
    logic [SUM_W-1:0]           quo_step [CHANNELS];
    logic [SUM_W-1:0]           quo_res  [CHANNELS];

    assign in_vec[CH_PITCH]   = samples.pitch_sample;
    assign in_vec[CH_ROLL]    = samples.roll_sample;
    assign in_vec[CH_YAW]     = samples.yaw_sample;
    assign in_vec[CH_ACCEL_X] = samples.accel_x_sample;
    assign in_vec[CH_ACCEL_Y] = samples.accel_y_sample;
    assign in_vec[CH_ACCEL_Z] = samples.accel_z_sample;

    assign samples.ready = (state_reg == ST_IDLE);
    assign accept        = samples.valid && samples.ready;

    assign pos_next = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_upd[c]  = sums_reg[c] + SUM_W'(signed'(sample_reg[c]))
                          - (full_reg ? SUM_W'(signed'(old_reg[c])) : SUM_W'(0));
            mag[c]      = sums_reg[c][SUM_W-1] ? SUM_W'(-sums_reg[c]) : sums_reg[c];
            shifted[c]  = {rem_reg[c], quo_reg[c][SUM_W-1]};
            ge[c]       = (shifted[c] >= {1'b0, filled_reg});
            rem_step[c] = ge[c] ? CNT_W'(shifted[c] - {1'b0, filled_reg})
                                : shifted[c][CNT_W-1:0];
            quo_step[c] = {quo_reg[c][SUM_W-2:0], ge[c]};
            quo_res[c]  = neg_reg[c] ? SUM_W'(-quo_reg[c]) : quo_reg[c];
            res_vec[c]  = quo_res[c][SAMPLE_W-1:0];
        end
    end

    // ring: read-first single port, old entry lands in old_reg
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_reg       <= ring[pos_reg];
            ring[pos_reg] <= in_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            filled_reg <= '0;
            full_reg   <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                sums_reg[c] <= '0;
            end
        end
        else
        begin
            if (accept)
            begin
                pos_reg  <= pos_next;
                full_reg <= (filled_reg == CNT_W'(WINDOW));
                if (filled_reg != CNT_W'(WINDOW))
                begin
                    filled_reg <= filled_reg + 1'b1;
                end
            end
            if (state_reg == ST_UPDATE)
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    sums_reg[c] <= sum_upd[c];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= in_vec;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (state_reg == ST_PREP)
            begin
                quo_reg[c] <= mag[c];
                rem_reg[c] <= '0;
                neg_reg[c] <= sums_reg[c][SUM_W-1];
            end
            else if (state_reg == ST_DIVIDE)
            begin
                quo_reg[c] <= quo_step[c];
                rem_reg[c] <= rem_step[c];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            mean_reg      <= '0;
            fill_out_reg  <= '0;
        end
        else
        begin
            // the load step offers the next beat itself
            if (out_valid_reg && means.ready && state_reg != ST_LOAD)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    bit_cnt_reg <= BIT_W'(SUM_W - 1);
                    state_reg   <= ST_DIVIDE;
                end
                ST_DIVIDE:
                begin
                    if (bit_cnt_reg == '0)
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else
                    begin
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                end
                ST_LOAD:
                begin
                    if (!out_valid_reg || means.ready)
                    begin
                        mean_reg      <= res_vec;
                        fill_out_reg  <= FILL_W'(filled_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign means.valid        = out_valid_reg;
    assign means.pitch_mean   = mean_reg[CH_PITCH];
    assign means.roll_mean    = mean_reg[CH_ROLL];
    assign means.yaw_mean     = mean_reg[CH_YAW];
    assign means.accel_x_mean = mean_reg[CH_ACCEL_X];
    assign means.accel_y_mean = mean_reg[CH_ACCEL_Y];
    assign means.accel_z_mean = mean_reg[CH_ACCEL_Z];
    assign means.fill_count   = fill_out_reg;

endmodule

### src/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks on the six-channel window mean, bound to the top level.
// ----------------------------------------------------------------------------
module swm_checker import swm_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [FILL_W-1:0] fill_count
);

    // a stalled result beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fill_count))
        else $error("fill count changed while stalled");

    // one sample at a time: busy right after an accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a sample is in work");

    // a result never shows up the cycle after a sample is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result offered too early");

endmodule

bind six_channel_window_mean swm_checker u_swm_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .out_valid  (means.valid),
    .out_ready  (means.ready),
    .fill_count (means.fill_count)
);
